// ----- src/assert_macros.svh -----
// assertion macros for the alert table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- src/tat_pkg.sv -----
`default_nettype none
package tat_pkg;
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_SWEEP  = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;
    localparam logic [2:0] REQ_FLAGS  = 3'd5;

    // compaction filter selected by the controller
    typedef enum logic [1:0] {
        FILT_TEST  = 2'd0,
        FILT_PFX   = 2'd1,
        FILT_EXP   = 2'd2,
        FILT_EVICT = 2'd3
    } filt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PURGE,
        ST_MATCH,
        ST_MIN,
        ST_EVICT,
        ST_APPEND,
        ST_COMPACT,
        ST_SIMPLE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic   scan_start;   // clear scan pointers
        logic   scan_step;    // process one slot
        filt_t  filt;
        logic   match_step;
        logic   min_step;
        logic   update_hit;
        logic   append;
        logic   do_simple;
        logic   load_out;
        logic   add_refused;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic has_real;
        logic hit_found;
        logic full;
        logic appended;
    } dp_sts_t;

    function automatic logic [63:0] key_form(input logic [63:0] raw, input int kb);
        logic [63:0] k;
        logic        stop;
        k = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= kb || raw[8*i +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                k[8*i +: 8] = raw[8*i +: 8];
        end
        return k;
    endfunction

    function automatic logic [63:0] prefix_mask(input logic [3:0] n, input int kb);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
            if (i < int'(n) && i < kb)
                m[8*i +: 8] = 8'hFF;
        return m;
    endfunction
endpackage
`default_nettype wire

// ----- src/tat_ctrl.sv -----
`default_nettype none
module tat_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire logic [2:0]      req_type,
    input  wire logic            is_test,
    output tat_pkg::dp_cmd_t     cmd,
    input  wire tat_pkg::dp_sts_t sts
);
    import tat_pkg::*;

    state_t state_reg, state_next;
    logic [2:0] req_reg;
    logic       test_reg;
    logic       accept;

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            req_reg   <= REQ_ADD;
            test_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                req_reg  <= req_type;
                test_reg <= is_test;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    case (req_type) inside
                        REQ_ADD:               state_next = is_test ? ST_MATCH : ST_PURGE;
                        REQ_REMOVE, REQ_SWEEP: state_next = ST_COMPACT;
                        default:               state_next = ST_SIMPLE;
                    endcase
                end
            ST_PURGE:   if (sts.scan_done) state_next = ST_MATCH;
            ST_MATCH:
                if (test_reg && sts.has_real)           state_next = ST_RESULT;
                else if (sts.hit_found)                 state_next = ST_RESULT;
                else if (sts.scan_done)                 state_next = sts.full ? ST_MIN : ST_APPEND;
            ST_MIN:     if (sts.scan_done) state_next = ST_EVICT;
            ST_EVICT:   if (sts.scan_done) state_next = ST_APPEND;
            ST_APPEND:  state_next = ST_RESULT;
            ST_COMPACT: if (sts.scan_done) state_next = ST_RESULT;
            ST_SIMPLE:  state_next = ST_RESULT;
            ST_RESULT:  if (!out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.filt = FILT_TEST;
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_RESULT);
        unique case (state_reg)
            ST_IDLE:    cmd.scan_start = 1'b1;
            ST_PURGE:
            begin
                cmd.scan_step = 1'b1;
                cmd.filt = FILT_TEST;
                if (sts.scan_done) cmd.scan_start = 1'b1;
            end
            ST_MATCH:
            begin
                if (test_reg && sts.has_real)
                    cmd.add_refused = 1'b1;
                else if (sts.hit_found)
                    cmd.update_hit = 1'b1;
                else if (sts.scan_done)
                    cmd.scan_start = 1'b1;
                else
                    cmd.match_step = 1'b1;
                if ((test_reg && sts.has_real) || sts.hit_found)
                    cmd.load_out = 1'b1;
            end
            ST_MIN:
            begin
                cmd.min_step = 1'b1;
                if (sts.scan_done) cmd.scan_start = 1'b1;
            end
            ST_EVICT:
            begin
                cmd.scan_step = 1'b1;
                cmd.filt = FILT_EVICT;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                cmd.load_out = 1'b1;
            end
            ST_COMPACT:
            begin
                cmd.scan_step = 1'b1;
                cmd.filt = (req_reg == REQ_REMOVE) ? FILT_PFX : FILT_EXP;
                cmd.load_out = sts.scan_done;
            end
            ST_SIMPLE:
            begin
                cmd.do_simple = 1'b1;
                cmd.load_out = 1'b1;
            end
            ST_RESULT:  ;
            default:    ;
        endcase
    end

    `include "assert_macros.svh"
    `ASSERT_NEVER(a_no_accept_busy, accept && state_reg != ST_IDLE, "accept while busy")
    `ASSERT_IMPL(a_result_holds, (out_valid && out_stall) |=> out_valid, "result dropped")
    `ASSERT_IMPL(a_accept_leaves_idle, accept |=> state_reg != ST_IDLE, "accept ignored")
endmodule
`default_nettype wire

// ----- src/tat_dp.sv -----
`default_nettype none
module tat_dp #(
    parameter int MAX_ENTRIES = 8,
    parameter int KEY_BYTES   = 8,
    parameter int CW          = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire tat_pkg::dp_cmd_t  cmd,
    output tat_pkg::dp_sts_t       sts,
    input  wire logic [2:0]        req_type,
    input  wire logic [31:0]       now_ms,
    input  wire logic [31:0]       timeout_ms,
    input  wire logic              is_test,
    input  wire logic [63:0]       key_text,
    input  wire logic [3:0]        prefix_len,
    input  wire logic [63:0]       latitude_bits,
    input  wire logic [63:0]       longitude_bits,
    input  wire logic signed [31:0] disaster_category,
    input  wire logic signed [31:0] alert_code,
    input  wire logic [63:0]       region_mask,
    input  wire logic [2:0]        entry_index,
    output logic                   result_flag,
    output logic                   changed_seen,
    output logic [3:0]             entry_count,
    output logic [1:0]             alert_mix,
    output logic [63:0]            entry_key,
    output logic [31:0]            entry_expiry,
    output logic                   entry_is_test,
    output logic [63:0]            entry_latitude,
    output logic [63:0]            entry_longitude,
    output logic signed [31:0]     entry_category,
    output logic signed [31:0]     entry_code,
    output logic [63:0]            entry_region
);
    import tat_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PW = 64 + 64 + 32 + 32 + 64;

    // slot store, registers kept separate so the scan can shift them down
    logic [63:0] key_reg  [MAX_ENTRIES];
    logic [31:0] exp_reg  [MAX_ENTRIES];
    logic        tst_reg  [MAX_ENTRIES];
    logic [PW-1:0] pay_reg [MAX_ENTRIES];

    logic [CW-1:0] count_reg, rd_reg, wr_reg;
    logic [IW-1:0] min_reg, hit_reg;
    logic          new_reg, chg_reg;
    logic          hit_found_reg;

    // captured request
    logic [2:0]    req_reg;
    logic [31:0]   now_reg, expn_reg;
    logic          it_reg;
    logic [63:0]   keyf_reg, mask_reg;
    logic [PW-1:0] payin_reg;
    logic [2:0]    idx_reg;

    logic [IW-1:0] rd_i, wr_i, cnt_i;
    logic          drop;
    logic          real_any, test_any;

    assign rd_i  = rd_reg[IW-1:0];
    assign wr_i  = wr_reg[IW-1:0];
    assign cnt_i = count_reg[IW-1:0];

    always_comb
    begin
        real_any = 1'b0;
        test_any = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (CW'(i) < count_reg)
            begin
                if (tst_reg[i]) test_any = 1'b1;
                else            real_any = 1'b1;
            end
    end

    always_comb
    begin
        case (cmd.filt)
            FILT_TEST:  drop = tst_reg[rd_i];
            FILT_PFX:   drop = ((key_reg[rd_i] ^ keyf_reg) & mask_reg) == 64'd0;
            FILT_EXP:   drop = !(exp_reg[rd_i] == 32'd0 || now_reg < exp_reg[rd_i]);
            default:    drop = (rd_i == min_reg);
        endcase
    end

    assign sts.scan_done = (rd_reg >= count_reg);
    assign sts.has_real  = real_any;
    assign sts.hit_found = hit_found_reg;
    assign sts.full      = (count_reg >= CW'(MAX_ENTRIES));
    assign sts.appended  = new_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            min_reg       <= '0;
            hit_reg       <= '0;
            new_reg       <= 1'b0;
            chg_reg       <= 1'b0;
            hit_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                rd_reg        <= '0;
                wr_reg        <= '0;
                hit_found_reg <= 1'b0;
                // keep the minimum found by a finished min search for the eviction
                if (!cmd.min_step)
                    min_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                if (rd_reg < count_reg)
                begin
                    rd_reg <= rd_reg + 1'b1;
                    if (drop)
                        chg_reg <= 1'b1;
                    else
                        wr_reg <= wr_reg + 1'b1;
                end
                else
                    count_reg <= wr_reg;
            end
            if (cmd.match_step && rd_reg < count_reg)
            begin
                rd_reg <= rd_reg + 1'b1;
                if (key_reg[rd_i] == keyf_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_reg       <= rd_i;
                end
            end
            if (cmd.min_step && rd_reg < count_reg)
            begin
                rd_reg <= rd_reg + 1'b1;
                if (exp_reg[rd_i] < exp_reg[min_reg])
                    min_reg <= rd_i;
            end
            if (cmd.update_hit && expn_reg > exp_reg[hit_reg])
                chg_reg <= 1'b1;
            if (cmd.append)
            begin
                count_reg <= count_reg + 1'b1;
                new_reg   <= 1'b1;
                chg_reg   <= 1'b1;
            end
            if (cmd.do_simple)
            begin
                if (req_reg == REQ_CLEAR)
                begin
                    if (count_reg != '0) chg_reg <= 1'b1;
                    count_reg <= '0;
                end
                if (req_reg == REQ_FLAGS)
                begin
                    new_reg <= 1'b0;
                    chg_reg <= 1'b0;
                end
            end
        end
    end

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && rd_reg < count_reg && !drop && wr_reg != rd_reg)
        begin
            key_reg[wr_i] <= key_reg[rd_i];
            exp_reg[wr_i] <= exp_reg[rd_i];
            tst_reg[wr_i] <= tst_reg[rd_i];
            pay_reg[wr_i] <= pay_reg[rd_i];
        end
        if (cmd.update_hit)
        begin
            if (expn_reg > exp_reg[hit_reg])
                exp_reg[hit_reg] <= expn_reg;
            tst_reg[hit_reg] <= it_reg;
            pay_reg[hit_reg] <= payin_reg;
        end
        if (cmd.append)
        begin
            key_reg[cnt_i] <= keyf_reg;
            exp_reg[cnt_i] <= expn_reg;
            tst_reg[cnt_i] <= it_reg;
            pay_reg[cnt_i] <= payin_reg;
        end
        if (accept)
        begin
            req_reg   <= req_type;
            now_reg   <= now_ms;
            expn_reg  <= now_ms + timeout_ms;
            it_reg    <= is_test;
            keyf_reg  <= key_form(key_text, KEY_BYTES);
            mask_reg  <= prefix_mask(prefix_len, KEY_BYTES);
            payin_reg <= {latitude_bits, longitude_bits, disaster_category, alert_code,
                          region_mask};
            idx_reg   <= entry_index;
        end
    end

    // result word; mix and count follow the table, which holds still while the word waits
    logic rd_ok;
    logic [IW-1:0] ri;
    assign ri    = IW'(idx_reg);
    assign rd_ok = ({1'b0, idx_reg} < 4'(count_reg)) && (32'(idx_reg) < MAX_ENTRIES);

    assign entry_count = 4'(count_reg);
    assign alert_mix   = {test_any, real_any};

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.do_simple && req_reg == REQ_READ && rd_ok)
            begin
                result_flag   <= 1'b1;
                changed_seen  <= 1'b0;
                entry_key     <= key_reg[ri];
                entry_expiry  <= exp_reg[ri];
                entry_is_test <= tst_reg[ri];
                {entry_latitude, entry_longitude, entry_category, entry_code,
                 entry_region} <= pay_reg[ri];
            end
            else
            begin
                result_flag   <= cmd.append ||
                                 (cmd.do_simple && req_reg == REQ_FLAGS && new_reg);
                changed_seen  <= cmd.do_simple && req_reg == REQ_FLAGS && chg_reg;
                entry_key     <= '0;
                entry_expiry  <= '0;
                entry_is_test <= 1'b0;
                {entry_latitude, entry_longitude, entry_category, entry_code,
                 entry_region} <= '0;
            end
        end
    end

    `include "assert_macros.svh"
    `ASSERT_NEVER(a_count_max, count_reg > CW'(MAX_ENTRIES), "count overflow")
    `ASSERT_NEVER(a_append_full, cmd.append && count_reg >= CW'(MAX_ENTRIES), "append full")
    `ASSERT_IMPL(a_append_flags, cmd.append |=> (new_reg && chg_reg), "flags missed")
endmodule
`default_nettype wire

// ----- src/timed_alert_table.sv -----
// channel | direction | handshake
// input   | in        | in_valid / in_stall
// result  | out       | out_valid / out_stall
// one request at a time; an add runs the scans it needs in this order
// (purge, key search, min search and eviction scans, one slot a cycle)
// remove and sweep run one compaction scan, other requests a single step
// reset empties the table and flags; in_stall high while busy
// a stalled result holds until taken
`default_nettype none
module timed_alert_table #(
    parameter int MAX_ENTRIES = 8,
    parameter int KEY_BYTES   = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire logic [2:0]        req_type,
    input  wire logic [31:0]       now_ms,
    input  wire logic [31:0]       timeout_ms,
    input  wire logic              is_test,
    input  wire logic [63:0]       key_text,
    input  wire logic [3:0]        prefix_len,
    input  wire logic [63:0]       latitude_bits,
    input  wire logic [63:0]       longitude_bits,
    input  wire logic signed [31:0] disaster_category,
    input  wire logic signed [31:0] alert_code,
    input  wire logic [63:0]       region_mask,
    input  wire logic [2:0]        entry_index,
    output logic                   result_flag,
    output logic                   changed_seen,
    output logic [3:0]             entry_count,
    output logic [1:0]             alert_mix,
    output logic [63:0]            entry_key,
    output logic [31:0]            entry_expiry,
    output logic                   entry_is_test,
    output logic [63:0]            entry_latitude,
    output logic [63:0]            entry_longitude,
    output logic signed [31:0]     entry_category,
    output logic signed [31:0]     entry_code,
    output logic [63:0]            entry_region
);
    import tat_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1) + 1;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    accept;

    assign accept = in_valid && !in_stall;

    tat_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .req_type(req_type), .is_test(is_test),
        .cmd(cmd), .sts(sts)
    );

    tat_dp #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BYTES(KEY_BYTES), .CW(CW)) u_dp (
        .clk(clk), .rst_n(rst_n), .accept(accept), .cmd(cmd), .sts(sts),
        .req_type(req_type), .now_ms(now_ms), .timeout_ms(timeout_ms),
        .is_test(is_test), .key_text(key_text), .prefix_len(prefix_len),
        .latitude_bits(latitude_bits), .longitude_bits(longitude_bits),
        .disaster_category(disaster_category), .alert_code(alert_code),
        .region_mask(region_mask), .entry_index(entry_index),
        .result_flag(result_flag), .changed_seen(changed_seen),
        .entry_count(entry_count), .alert_mix(alert_mix),
        .entry_key(entry_key), .entry_expiry(entry_expiry),
        .entry_is_test(entry_is_test), .entry_latitude(entry_latitude),
        .entry_longitude(entry_longitude), .entry_category(entry_category),
        .entry_code(entry_code), .entry_region(entry_region)
    );
endmodule
`default_nettype wire
